### design/ufls_pkg.sv
// ----------------------------------------------------------------------------
// ufls_pkg
// Shared types and constants for the multistage under-frequency shed relay.
// ----------------------------------------------------------------------------
package ufls_pkg;

    localparam int STAGES       = 4;   // active stage cells, 1..4
    localparam int SETTING_REGS = 4;   // stage setting registers always stored
    localparam int TIMER_BITS   = 24;  // elapsed counter width, 8..32
    localparam int FREQ_W       = 20;
    localparam int TICK_W       = 24;
    localparam int FRAC_W       = 16;
    localparam int MASK_W       = 4;
    localparam int SHED_W       = 18;
    localparam int CMP_W        = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;

    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 6;
    localparam int REG_IDX_W    = 3;

    localparam logic [REG_IDX_W-1:0] REG_STAGE0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STAGE1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STAGE2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STAGE3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BREAKER = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DELAY = 2'd1,
        PH_BREAK = 2'd2,
        PH_TRIP  = 2'd3
    } t_phase;

    typedef logic [MASK_W-1:0] t_mask;

    // Packed to match the register layout: frac 59:44, delay 43:20, thr 19:0
    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic [TICK_W-1:0] delay;
        logic [FREQ_W-1:0] thr;
    } t_stage_cfg;

    typedef struct packed {
        logic [FREQ_W-1:0] filtered_frequency;
        logic              relay_enable;
    } t_in;

    typedef struct packed {
        t_mask             tripped_mask;
        t_mask             new_trip_mask;
        t_mask             delay_running_mask;
        t_mask             breaker_running_mask;
        logic [SHED_W-1:0] shed_total;
    } t_out;

    // What travels from cell to cell: the sample and the partial result
    typedef struct packed {
        t_in  smp;
        t_out res;
    } t_chain;

endpackage

### design/multistage_underfrequency_shed_relay_top.sv
// ----------------------------------------------------------------------------
// multistage_underfrequency_shed_relay_top
// Under-frequency load-shedding relay built as a chain of stage cells.
// ----------------------------------------------------------------------------
// Pipeline: one register per stage cell between input transaction and
//   o_out_valid; the last cell's register is the output register.
// Throughput: one transaction per cycle while the output does not stall;
//   per-cell ready lets bubbles collapse while the output stalls.
// Reset (synchronous, active low): all stages idle, timers zero, settings
//   zero, the cell chain empty.
// ----------------------------------------------------------------------------
module multistage_underfrequency_shed_relay_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ufls_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ufls_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ufls_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ufls_pkg::t_in                      i_in_data,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ufls_pkg::t_out                     o_out_data
);

    ufls_pkg::t_stage_cfg                w_stage_cfg [ufls_pkg::SETTING_REGS];
    logic [ufls_pkg::TICK_W-1:0]         w_breaker_ticks;

    // Chain links: index g feeds cell g, index STAGES is the output
    ufls_pkg::t_chain                    w_chain [ufls_pkg::STAGES+1];
    logic                                w_valid [ufls_pkg::STAGES+1];
    logic                                w_ready [ufls_pkg::STAGES+1];

    ufls_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_stage_cfg     (w_stage_cfg),
        .o_breaker_ticks (w_breaker_ticks)
    );

    // Head of the chain: the sample enters with an empty partial result.
    assign w_chain[0] = {i_in_data, ufls_pkg::t_out'('0)};
    assign w_valid[0] = i_in_valid;
    assign o_in_ready = w_ready[0];

    // Each cell owns one stage; it sees every sample in order, after its
    // upstream neighbor has registered it, and ORs its bits into the result.
    for (genvar g = 0; g < ufls_pkg::STAGES; g++) begin : g_cell
        ufls_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_stage_bit     (ufls_pkg::t_mask'(1) << g),
            .i_cfg           (w_stage_cfg[g]),
            .i_breaker_ticks (w_breaker_ticks),
            .i_valid         (w_valid[g]),
            .o_ready         (w_ready[g]),
            .i_chain         (w_chain[g]),
            .o_valid         (w_valid[g+1]),
            .i_ready         (w_ready[g+1]),
            .o_chain         (w_chain[g+1])
        );
    end

    assign w_ready[ufls_pkg::STAGES] = i_out_ready;
    assign o_out_valid               = w_valid[ufls_pkg::STAGES];
    assign o_out_data                = w_chain[ufls_pkg::STAGES].res;

`ifndef SYNTHESIS
    // A fresh trip is always also reported as tripped.
    a_fresh_in_tripped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.new_trip_mask & ~o_out_data.tripped_mask) == '0))
        else $error("new trip bit without tripped bit");

    // A stage is in at most one phase.
    a_phase_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.tripped_mask & o_out_data.delay_running_mask) == '0) &&
            ((o_out_data.tripped_mask & o_out_data.breaker_running_mask) == '0) &&
            ((o_out_data.delay_running_mask & o_out_data.breaker_running_mask) == '0))
        else $error("stage reported in two phases");

    // Nothing shed without a tripped stage.
    a_shed_needs_trip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.tripped_mask == '0) |-> (o_out_data.shed_total == '0))
        else $error("shed total without tripped stage");
`endif

endmodule

### design/ufls_regs.sv
// ----------------------------------------------------------------------------
// ufls_regs
// APB register file: four stage settings and the shared breaker time.
// ----------------------------------------------------------------------------
module ufls_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ufls_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ufls_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ufls_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ufls_pkg::t_stage_cfg                o_stage_cfg [ufls_pkg::SETTING_REGS],
    output logic [ufls_pkg::TICK_W-1:0]         o_breaker_ticks
);

    ufls_pkg::t_stage_cfg                r_stage_cfg [ufls_pkg::SETTING_REGS];
    logic [ufls_pkg::TICK_W-1:0]         r_breaker_ticks;
    logic [ufls_pkg::REG_IDX_W-1:0]      w_idx;
    logic                                w_wr;

    assign w_idx  = paddr[ufls_pkg::APB_ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ufls_pkg::SETTING_REGS; k++) begin
                r_stage_cfg[k] <= '0;
            end
            r_breaker_ticks <= '0;
        end else if (w_wr) begin
            case (w_idx)
                ufls_pkg::REG_STAGE0:  r_stage_cfg[0] <= pwdata[59:0];
                ufls_pkg::REG_STAGE1:  r_stage_cfg[1] <= pwdata[59:0];
                ufls_pkg::REG_STAGE2:  r_stage_cfg[2] <= pwdata[59:0];
                ufls_pkg::REG_STAGE3:  r_stage_cfg[3] <= pwdata[59:0];
                ufls_pkg::REG_BREAKER: r_breaker_ticks <= pwdata[ufls_pkg::TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            ufls_pkg::REG_STAGE0:  prdata = {4'd0, r_stage_cfg[0]};
            ufls_pkg::REG_STAGE1:  prdata = {4'd0, r_stage_cfg[1]};
            ufls_pkg::REG_STAGE2:  prdata = {4'd0, r_stage_cfg[2]};
            ufls_pkg::REG_STAGE3:  prdata = {4'd0, r_stage_cfg[3]};
            ufls_pkg::REG_BREAKER: prdata = {40'd0, r_breaker_ticks};
            default:               prdata = '0;
        endcase
    end

    assign o_stage_cfg     = r_stage_cfg;
    assign o_breaker_ticks = r_breaker_ticks;

endmodule

### design/ufls_cell.sv
// ----------------------------------------------------------------------------
// ufls_cell
// One stage machine with its timer; adds its bits to the passing result.
// ----------------------------------------------------------------------------
module ufls_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ufls_pkg::t_mask               i_stage_bit,
    input  ufls_pkg::t_stage_cfg          i_cfg,
    input  logic [ufls_pkg::TICK_W-1:0]   i_breaker_ticks,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ufls_pkg::t_chain              i_chain,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ufls_pkg::t_chain              o_chain
);

    localparam logic [ufls_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;

    logic                                r_valid;
    ufls_pkg::t_chain                    r_chain;
    ufls_pkg::t_chain                    n_chain;
    ufls_pkg::t_phase                    r_phase;
    ufls_pkg::t_phase                    n_phase;
    logic [ufls_pkg::TIMER_BITS-1:0]     r_elapsed;
    logic [ufls_pkg::TIMER_BITS-1:0]     n_elapsed;
    logic [ufls_pkg::TIMER_BITS-1:0]     w_el_inc;
    logic                                w_accept;
    logic                                w_fresh;
    logic [ufls_pkg::FREQ_W-1:0]         w_f;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_f      = i_chain.smp.filtered_frequency;

    always_comb begin
        w_el_inc = r_elapsed;
        if ((r_phase == ufls_pkg::PH_DELAY || r_phase == ufls_pkg::PH_BREAK)
            && r_elapsed != TIMER_MAX) begin
            w_el_inc = r_elapsed + 1'b1;
        end

        n_phase   = r_phase;
        n_elapsed = w_el_inc;
        w_fresh   = 1'b0;
        if (i_chain.smp.relay_enable) begin
            case (r_phase)
                ufls_pkg::PH_IDLE: begin
                    if (w_f < i_cfg.thr) begin
                        n_phase   = ufls_pkg::PH_DELAY;
                        n_elapsed = '0;
                    end
                end
                ufls_pkg::PH_DELAY: begin
                    if (ufls_pkg::CMP_W'(w_el_inc) >= ufls_pkg::CMP_W'(i_cfg.delay)) begin
                        n_phase   = ufls_pkg::PH_BREAK;
                        n_elapsed = '0;
                    end else if (w_f > i_cfg.thr) begin
                        n_phase   = ufls_pkg::PH_IDLE;
                        n_elapsed = '0;
                    end
                end
                ufls_pkg::PH_BREAK: begin
                    if (ufls_pkg::CMP_W'(w_el_inc) >= ufls_pkg::CMP_W'(i_breaker_ticks)) begin
                        n_phase   = ufls_pkg::PH_TRIP;
                        n_elapsed = '0;
                        w_fresh   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        n_chain = i_chain;
        if (w_fresh) begin
            n_chain.res.new_trip_mask = i_chain.res.new_trip_mask | i_stage_bit;
        end
        case (n_phase)
            ufls_pkg::PH_TRIP: begin
                n_chain.res.tripped_mask = i_chain.res.tripped_mask | i_stage_bit;
                n_chain.res.shed_total   = i_chain.res.shed_total
                                         + ufls_pkg::SHED_W'(i_cfg.frac);
            end
            ufls_pkg::PH_DELAY: begin
                n_chain.res.delay_running_mask =
                    i_chain.res.delay_running_mask | i_stage_bit;
            end
            ufls_pkg::PH_BREAK: begin
                n_chain.res.breaker_running_mask =
                    i_chain.res.breaker_running_mask | i_stage_bit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_phase   <= ufls_pkg::PH_IDLE;
            r_elapsed <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_accept) begin
                r_phase   <= n_phase;
                r_elapsed <= n_elapsed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chain <= n_chain;
        end
    end

    assign o_valid = r_valid;
    assign o_chain = r_chain;

endmodule

### verif/multistage_underfrequency_shed_relay_checker.sv
// ----------------------------------------------------------------------------
// multistage_underfrequency_shed_relay_checker
// Scoreboard for the shed relay. It follows the register writes and every
// sample transaction, runs its own copy of the four stage machines, and
// compares each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module multistage_underfrequency_shed_relay_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [ufls_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [ufls_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic                            i_pready,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  ufls_pkg::t_in                   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  ufls_pkg::t_out                  i_out_data,
    input  logic                            i_end_check,
    output int                              o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ufls_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;

    ufls_pkg::t_stage_cfg            stage_cfg [ufls_pkg::SETTING_REGS];
    logic [ufls_pkg::TICK_W-1:0]     breaker_ticks;
    ufls_pkg::t_phase                stage_phase [ufls_pkg::STAGES];
    logic [ufls_pkg::TIMER_BITS-1:0] stage_elapsed [ufls_pkg::STAGES];

    ufls_pkg::t_out                  pending_reports [$];
    ufls_pkg::t_out                  want;
    logic [ufls_pkg::REG_IDX_W-1:0]  reg_idx;
    int                              n_results;
    int                              n_fail;
    bit                              end_checked;

    assign o_fail_count = n_fail;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, n_results, what, got, exp_val);
        n_fail++;
    endtask

    task automatic compare_field(input string what, input int got, input int exp_val);
        if (got !== exp_val) begin
            report_mismatch(what, got, exp_val);
        end
    endtask

    // One tick of all stage machines; updates the shadow state
    function automatic ufls_pkg::t_out relay_tick(input ufls_pkg::t_in smp);
        ufls_pkg::t_out   res;
        ufls_pkg::t_phase ph;
        res = '0;
        for (int s = 0; s < ufls_pkg::STAGES; s++) begin
            ph = stage_phase[s];
            if ((ph == ufls_pkg::PH_DELAY || ph == ufls_pkg::PH_BREAK)
                && stage_elapsed[s] != TIMER_MAX) begin
                stage_elapsed[s] = stage_elapsed[s] + 1'b1;
            end
            if (smp.relay_enable) begin
                case (ph)
                    ufls_pkg::PH_IDLE: begin
                        if (smp.filtered_frequency < stage_cfg[s].thr) begin
                            ph = ufls_pkg::PH_DELAY;
                            stage_elapsed[s] = '0;
                        end
                    end
                    ufls_pkg::PH_DELAY: begin
                        if (stage_elapsed[s] >= stage_cfg[s].delay) begin
                            ph = ufls_pkg::PH_BREAK;
                            stage_elapsed[s] = '0;
                        end else if (smp.filtered_frequency > stage_cfg[s].thr) begin
                            ph = ufls_pkg::PH_IDLE;
                            stage_elapsed[s] = '0;
                        end
                    end
                    ufls_pkg::PH_BREAK: begin
                        if (stage_elapsed[s] >= breaker_ticks) begin
                            ph = ufls_pkg::PH_TRIP;
                            stage_elapsed[s] = '0;
                            res.new_trip_mask[s] = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            stage_phase[s] = ph;
            case (ph)
                ufls_pkg::PH_TRIP: begin
                    res.tripped_mask[s] = 1'b1;
                    res.shed_total = res.shed_total
                                   + ufls_pkg::SHED_W'(stage_cfg[s].frac);
                end
                ufls_pkg::PH_DELAY: res.delay_running_mask[s] = 1'b1;
                ufls_pkg::PH_BREAK: res.breaker_running_mask[s] = 1'b1;
                default: ;
            endcase
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ufls_pkg::SETTING_REGS; s++) begin
                stage_cfg[s] = '0;
            end
            for (int s = 0; s < ufls_pkg::STAGES; s++) begin
                stage_phase[s]   = ufls_pkg::PH_IDLE;
                stage_elapsed[s] = '0;
            end
            breaker_ticks = '0;
            pending_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_idx = i_paddr[ufls_pkg::APB_ADDR_W-1:3];
                if (reg_idx < ufls_pkg::SETTING_REGS) begin
                    stage_cfg[reg_idx] = i_pwdata[$bits(ufls_pkg::t_stage_cfg)-1:0];
                end else if (reg_idx == ufls_pkg::REG_BREAKER) begin
                    breaker_ticks = i_pwdata[ufls_pkg::TICK_W-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_reports.push_back(relay_tick(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch("unexpected result", int'(i_out_data), 0);
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("tripped_mask", int'(i_out_data.tripped_mask),
                                  int'(want.tripped_mask));
                    compare_field("new_trip_mask", int'(i_out_data.new_trip_mask),
                                  int'(want.new_trip_mask));
                    compare_field("delay_running_mask",
                                  int'(i_out_data.delay_running_mask),
                                  int'(want.delay_running_mask));
                    compare_field("breaker_running_mask",
                                  int'(i_out_data.breaker_running_mask),
                                  int'(want.breaker_running_mask));
                    compare_field("shed_total", int'(i_out_data.shed_total),
                                  int'(want.shed_total));
                end
                n_results++;
            end
            if (i_end_check && !end_checked) begin
                end_checked = 1'b1;
                if (pending_reports.size() != 0) begin
                    report_mismatch("results never delivered", 0, pending_reports.size());
                end
            end
        end
    end

endmodule

### verif/multistage_underfrequency_shed_relay_top_tb.sv
// ----------------------------------------------------------------------------
// multistage_underfrequency_shed_relay_top_tb
// Drives frequency samples and stage settings into the shed relay, with
// random idle cycles on both channels, and leaves all checking to the
// scoreboard beside the block. Ends with the verdict from its failure count.
// ----------------------------------------------------------------------------
module multistage_underfrequency_shed_relay_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Frequencies in Q8.12 Hz: 50 Hz nominal, dips reach down to about 46 Hz
    localparam logic [ufls_pkg::FREQ_W-1:0] F_MAX      = '1;
    localparam logic [ufls_pkg::FREQ_W-1:0] F_NOMINAL  = 20'h32000;
    localparam logic [ufls_pkg::FREQ_W-1:0] F_DIP_LOW  = 20'h2E000;
    localparam logic [ufls_pkg::FREQ_W-1:0] F_THR_LOW  = 20'h30000;
    localparam int                          THR_SPAN   = 'h2000;
    localparam int                          CYCLE_LIMIT = 1_000_000;
    // First index past the register list; writes there must be ignored
    localparam logic [ufls_pkg::REG_IDX_W-1:0] REG_SPARE = ufls_pkg::REG_BREAKER + 1'b1;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ufls_pkg::APB_ADDR_W-1:0] paddr;
    logic [ufls_pkg::APB_DATA_W-1:0] pwdata;
    logic [ufls_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            i_in_valid;
    logic                            o_in_ready;
    ufls_pkg::t_in                   i_in_data;
    logic                            o_out_valid;
    logic                            i_out_ready;
    ufls_pkg::t_out                  o_out_data;

    logic                            end_check;
    int                              fail_count;
    int                              n_sent;       // sample transactions accepted
    int                              n_received;   // result transactions accepted
    int                              cycles;
    int                              tx_calm;      // items left in a no-gap burst, sender
    int                              rx_calm;      // same for the receiver
    bit                              hold_req;     // sender asks the receiver for a long stall
    bit                              hold_done;
    logic [ufls_pkg::FREQ_W-1:0]     stage_thr [ufls_pkg::SETTING_REGS];  // thresholds last written

    multistage_underfrequency_shed_relay_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    multistage_underfrequency_shed_relay_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_end_check  (end_check),
        .o_fail_count (fail_count)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Transaction counters; the difference is what is still in flight
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            n_sent <= n_sent + 1;
        end
        if (o_out_valid && i_out_ready) begin
            n_received <= n_received + 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("multistage_underfrequency_shed_relay_top_tb failed");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long. Now and then a
    // burst of zero-gap transactions.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Called at a falling edge; returns at a falling edge
    task automatic send_sample(input logic [ufls_pkg::FREQ_W-1:0] freq, input logic enable);
        ufls_pkg::t_in smp;
        int            gap;
        smp.filtered_frequency = freq;
        smp.relay_enable       = enable;
        i_in_data  <= smp;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Stop offering and wait until every result is out; one result per
    // sample, so nothing is left in the stage chain after that
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (n_received != n_sent) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Setup phase, then access phase, then the bus returns to idle
    task automatic reg_write(input logic [ufls_pkg::REG_IDX_W-1:0] idx,
                             input logic [ufls_pkg::APB_DATA_W-1:0] value);
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Junk in the bits above the 60-bit setting; the block must drop them
    task automatic write_stage(input int s, input ufls_pkg::t_stage_cfg cfg);
        logic [ufls_pkg::APB_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        reg_write(ufls_pkg::REG_STAGE0 + ufls_pkg::REG_IDX_W'(s),
                  {junk[ufls_pkg::APB_DATA_W-1:$bits(ufls_pkg::t_stage_cfg)], cfg});
        stage_thr[s] = cfg.thr;
    endtask

    task automatic write_breaker(input logic [ufls_pkg::TICK_W-1:0] ticks);
        logic [ufls_pkg::APB_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        reg_write(ufls_pkg::REG_BREAKER, {junk[ufls_pkg::APB_DATA_W-1:ufls_pkg::TICK_W], ticks});
    endtask

    // Thresholds near 50 Hz, delays mostly longer than short dips so that
    // stages go in and out of delaying many times before any of them trips.
    // Stage 0 keeps an endless delay in the first phases.
    task automatic configure_phase(input int p);
        ufls_pkg::t_stage_cfg cfg;
        for (int s = 0; s < ufls_pkg::SETTING_REGS; s++) begin
            cfg.thr   = F_THR_LOW + ufls_pkg::FREQ_W'($urandom_range(0, THR_SPAN));
            cfg.delay = ($urandom_range(0, 19) == 0) ? '0 :
                        ufls_pkg::TICK_W'($urandom_range(30, 200));
            if (s == 0 && p < 2) begin
                cfg.delay = '1;
            end
            cfg.frac  = (p == 4) ? '0 : ufls_pkg::FRAC_W'($urandom);
            write_stage(s, cfg);
        end
        write_breaker((p == 1) ? '0 : ufls_pkg::TICK_W'($urandom_range(1, 60)));
    endtask

    // Samples as a grid would see them: nominal stretches, short dips that
    // recover, rare long dips that run into the breaker, and some noise.
    task automatic run_phase(input int p, input int n_items);
        int                          k;
        int                          len;
        int                          pick;
        bit                          paused;
        logic [ufls_pkg::FREQ_W-1:0] f;
        k      = 0;
        paused = 1'b0;
        while (k < n_items) begin
            // long output stall while samples keep coming
            if (p == 2 && k >= 150) begin
                hold_req = 1'b1;
            end
            // sender pause until the block is empty
            if (p == 3 && k >= 170 && !paused) begin
                paused = 1'b1;
                drain_block();
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_sample(ufls_pkg::FREQ_W'($urandom), 1'($urandom));
                k++;
            end else begin
                len = (pick < 45) ? $urandom_range(1, 8) :
                      (pick < 98) ? $urandom_range(1, 30) : $urandom_range(100, 300);
                if (len > n_items - k) begin
                    len = n_items - k;
                end
                repeat (len) begin
                    if (pick < 45) begin
                        f = F_NOMINAL + ufls_pkg::FREQ_W'($urandom_range(0, 'h800));
                    end else if ($urandom_range(0, 19) == 0) begin
                        f = stage_thr[$urandom_range(0, ufls_pkg::SETTING_REGS - 1)];
                    end else begin
                        f = ufls_pkg::FREQ_W'($urandom_range(F_DIP_LOW, F_NOMINAL));
                    end
                    send_sample(f, $urandom_range(0, 24) != 0);
                end
                k += len;
            end
        end
    endtask

    // Receiver: random ready runs and stalls, plus one long stall on request
    initial begin
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (100) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                int gap;
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
                gap = pick_gap(rx_calm);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        ufls_pkg::t_stage_cfg cfg;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        end_check  = 1'b0;
        n_sent     = 0;
        n_received = 0;
        cycles     = 0;
        tx_calm    = 0;
        rx_calm    = 0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        for (int s = 0; s < ufls_pkg::SETTING_REGS; s++) begin
            stage_thr[s] = '0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: all thresholds zero, nothing can start
        send_sample('0, 1'b1);
        send_sample(F_MAX, 1'b1);
        send_sample('0, 1'b0);
        send_sample(F_MAX, 1'b0);
        drain_block();

        // Stage 0: endless delay. Stage 1: three-tick delay.
        // Stage 2: zero threshold, never starts. Stage 3: zero delay.
        // Breaker at its maximum so nothing trips yet.
        cfg = '{frac: 16'h1234, delay: '1, thr: 20'h31000};
        write_stage(0, cfg);
        cfg = '{frac: 16'h8000, delay: 24'd3, thr: F_THR_LOW};
        write_stage(1, cfg);
        cfg = '{frac: '1, delay: 24'd0, thr: '0};
        write_stage(2, cfg);
        cfg = '{frac: '1, delay: 24'd0, thr: F_NOMINAL};
        write_stage(3, cfg);
        write_breaker('1);
        reg_write(REG_SPARE, {$urandom, $urandom});

        send_sample(F_NOMINAL, 1'b1);           // equal to stage 3 threshold: stays idle
        send_sample(F_NOMINAL - 1'b1, 1'b1);    // stage 3 starts its delay
        send_sample(F_NOMINAL - 1'b1, 1'b0);    // relay off: timer runs, no moves
        send_sample(F_NOMINAL, 1'b1);           // zero delay elapsed, to breaker
        send_sample('0, 1'b1);                  // stages 0 and 1 start
        send_sample(F_THR_LOW, 1'b1);           // equal: stage 1 keeps delaying
        send_sample(F_THR_LOW + 1'b1, 1'b1);    // recovery before delay: back to idle
        send_sample('0, 1'b0);
        send_sample('0, 1'b1);                  // stage 1 starts again
        repeat (4) send_sample('0, 1'b1);       // stage 1 delay runs out
        send_sample(F_MAX, 1'b1);               // stage 0 recovers
        send_sample(F_MAX, 1'b0);
        drain_block();

        for (int p = 0; p < 5; p++) begin
            configure_phase(p);
            run_phase(p, 340);
            drain_block();
        end

        // Everything trips at once: highest thresholds, zero delay and
        // breaker time, full shed fractions
        cfg = '{frac: '1, delay: '0, thr: '1};
        for (int s = 0; s < ufls_pkg::SETTING_REGS; s++) begin
            write_stage(s, cfg);
        end
        write_breaker('0);
        run_phase(5, 130);
        drain_block();

        repeat (2 * ufls_pkg::STAGES) @(posedge i_clk);
        @(negedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("multistage_underfrequency_shed_relay_top_tb passed");
        end else begin
            $display("multistage_underfrequency_shed_relay_top_tb failed");
        end
        $finish;
    end

endmodule
